FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SICP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SICP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sicp_pkg.sv
`timescale 1ns / 1ps

package sicp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_SHAPE,
		ST_UPDATE,
		ST_ALLOC,
		ST_FULL
	} state_t;

	typedef enum logic [1:0] {
		KIND_MONO = 2'd0,
		KIND_POLY = 2'd1,
		KIND_MEGA = 2'd2
	} kind_t;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

FILE: rtl/sicp_ram.sv
`timescale 1ns / 1ps

module sicp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/shape_inline_cache_profiler_unit.sv
`timescale 1ns / 1ps

// Channel   Signals                                   Beat taken when
// -------   ---------------------------------------   ---------------------
// in        start, site_address, shape_code           start && !busy
// out       done, slot_number, newly_allocated,       done (one cycle)
//           site_kind, seen_count, distinct_shapes,
//           table_full
//
// Busy covers a scan of the used slot keys up to a match. On a miss an allocate
// or full state follows; on a hit, a load, a scan of the slot's stored shapes up
// to a match, and an update. Done is shown in the cycle after busy ends; one slot
// key, then one shape, per cycle through the comparator.
// Reset clears the sequencer and the slot use count; no clearing pass.
// A new beat may be taken in the cycle done is shown. Results cannot stall.
module shape_inline_cache_profiler_unit #(
	parameter int SLOT_COUNT = 64,
	parameter int POLY_LIMIT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] site_address,
	input  logic [63:0] shape_code,
	output logic        busy,
	output logic        done,
	output logic [5:0]  slot_number,
	output logic        newly_allocated,
	output logic [1:0]  site_kind,
	output logic [31:0] seen_count,
	output logic [2:0]  distinct_shapes,
	output logic        table_full
);

	import sicp_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int UW = $clog2(SLOT_COUNT + 1);
	localparam int FW = $clog2(POLY_LIMIT + 1);
	localparam int SH_DEPTH = SLOT_COUNT * POLY_LIMIT;
	localparam int HW = (SH_DEPTH > 1) ? $clog2(SH_DEPTH) : 1;

	state_t state_q, state_d;

	logic [UW-1:0] used_q;
	logic [UW-1:0] idx_q;
	logic [FW-1:0] j_q;
	logic          rd_vld_s1;
	logic [UW-1:0] rd_idx_s1;
	logic          found_q;
	logic [SW-1:0] slot_q;
	logic [31:0]   addr_q;
	logic [63:0]   shape_q;

	logic [31:0]   key_rd;
	logic [31:0]   cnt_rd;
	logic [1:0]    kind_rd;
	logic [FW-1:0] fill_rd;
	logic [63:0]   sh_rd;

	logic [63:0] cmp_a, cmp_b;
	logic        match;
	logic        issue_slot, issue_shape;

	logic [HW-1:0] sh_raddr, sh_waddr;
	logic [FW-1:0] sh_off;

	logic          key_we, cnt_we, kind_we, fill_we, sh_we;
	logic [31:0]   cnt_wd;
	logic [1:0]    kind_wd;
	logic [FW-1:0] fill_wd;

	logic          res_ld;
	logic [31:0]   slot_ext, fill_ext;
	logic          res_new, res_full;
	logic [1:0]    res_kind;
	logic [31:0]   res_cnt;
	logic [FW-1:0] res_fill;
	logic [31:0]   cnt_inc;
	logic          append;

	sicp_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_key (
		.clk(clk), .we(key_we), .waddr(slot_q), .wdata(addr_q),
		.raddr(idx_q[SW-1:0]), .rdata(key_rd)
	);

	sicp_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(slot_q), .wdata(cnt_wd),
		.raddr(slot_q), .rdata(cnt_rd)
	);

	sicp_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_kind (
		.clk(clk), .we(kind_we), .waddr(slot_q), .wdata(kind_wd),
		.raddr(slot_q), .rdata(kind_rd)
	);

	sicp_ram #(.WIDTH(FW), .DEPTH(SLOT_COUNT)) u_fill (
		.clk(clk), .we(fill_we), .waddr(slot_q), .wdata(fill_wd),
		.raddr(slot_q), .rdata(fill_rd)
	);

	sicp_ram #(.WIDTH(64), .DEPTH(SH_DEPTH)) u_shape (
		.clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(shape_q),
		.raddr(sh_raddr), .rdata(sh_rd)
	);

	assign sh_raddr = HW'(32'(slot_q) * POLY_LIMIT + 32'(j_q));
	assign sh_waddr = HW'(32'(slot_q) * POLY_LIMIT + 32'(sh_off));

	assign cmp_a = (state_q == ST_SCAN) ? {32'b0, key_rd} : sh_rd;
	assign cmp_b = (state_q == ST_SCAN) ? {32'b0, addr_q} : shape_q;
	assign match = rd_vld_s1 && (cmp_a == cmp_b);

	assign issue_slot  = (idx_q < used_q);
	assign issue_shape = (j_q < fill_rd);

	assign cnt_inc = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 32'd1;
	assign append  = !found_q && (kind_t'(kind_rd) != KIND_MEGA)
		&& (32'(fill_rd) < POLY_LIMIT);

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = ST_LOAD;
				end else if (!rd_vld_s1 && !issue_slot) begin
					state_d = (32'(used_q) >= SLOT_COUNT) ? ST_FULL : ST_ALLOC;
				end
			end
			ST_LOAD:   state_d = ST_SHAPE;
			ST_SHAPE: begin
				if (match || (!rd_vld_s1 && !issue_shape)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_IDLE;
			ST_ALLOC:  state_d = ST_IDLE;
			ST_FULL:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		key_we   = 1'b0;
		cnt_we   = 1'b0;
		kind_we  = 1'b0;
		fill_we  = 1'b0;
		sh_we    = 1'b0;
		sh_off   = '0;
		cnt_wd   = 32'd1;
		kind_wd  = KIND_MONO;
		fill_wd  = FW'(1);
		res_ld   = 1'b0;
		res_new  = 1'b0;
		res_full = 1'b0;
		res_kind = KIND_MONO;
		res_cnt  = '0;
		res_fill = '0;
		case (state_q)
			ST_ALLOC: begin
				key_we   = 1'b1;
				cnt_we   = 1'b1;
				kind_we  = 1'b1;
				fill_we  = 1'b1;
				sh_we    = 1'b1;
				res_ld   = 1'b1;
				res_new  = 1'b1;
				res_cnt  = 32'd1;
				res_fill = FW'(1);
			end
			ST_UPDATE: begin
				cnt_we  = 1'b1;
				kind_we = 1'b1;
				fill_we = 1'b1;
				cnt_wd  = cnt_inc;
				sh_off  = fill_rd;
				fill_wd = fill_rd;
				kind_wd = kind_rd;
				if (append) begin
					sh_we   = 1'b1;
					fill_wd = fill_rd + FW'(1);
					kind_wd = KIND_POLY;
				end else if (!found_q) begin
					kind_wd = KIND_MEGA;
				end
				res_ld   = 1'b1;
				res_kind = kind_wd;
				res_cnt  = cnt_inc;
				res_fill = fill_wd;
			end
			ST_FULL: begin
				res_ld   = 1'b1;
				res_full = 1'b1;
			end
			default: begin
				res_ld = 1'b0;
			end
		endcase
	end

	assign slot_ext = (state_q == ST_FULL) ? 32'd0 : 32'(slot_q);
	assign fill_ext = 32'(res_fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			idx_q     <= '0;
			j_q       <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_ld;
			case (state_q)
				ST_IDLE: begin
					idx_q     <= '0;
					rd_vld_s1 <= 1'b0;
				end
				ST_SCAN: begin
					if (issue_slot) begin
						idx_q <= idx_q + UW'(1);
					end
					rd_vld_s1 <= issue_slot;
				end
				ST_LOAD: begin
					j_q       <= '0;
					rd_vld_s1 <= 1'b0;
				end
				ST_SHAPE: begin
					if (issue_shape) begin
						j_q <= j_q + FW'(1);
					end
					rd_vld_s1 <= issue_shape;
				end
				ST_ALLOC: begin
					used_q <= used_q + UW'(1);
				end
				default: begin
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			addr_q  <= site_address;
			shape_q <= shape_code;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_s1 <= idx_q;
			if (match) begin
				slot_q <= rd_idx_s1[SW-1:0];
			end else if (!rd_vld_s1 && !issue_slot) begin
				slot_q <= used_q[SW-1:0];
			end
		end
		if (state_q == ST_SHAPE) begin
			found_q <= match;
		end
		if (res_ld) begin
			slot_number     <= slot_ext[5:0];
			newly_allocated <= res_new;
			site_kind       <= res_kind;
			seen_count      <= res_cnt;
			distinct_shapes <= fill_ext[2:0];
			table_full      <= res_full;
		end
	end

endmodule

FILE: rtl/sicp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sicp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic [31:0] site_address,
	input logic [63:0] shape_code,
	input logic        busy,
	input logic        done,
	input logic [5:0]  slot_number,
	input logic        newly_allocated,
	input logic [1:0]  site_kind,
	input logic [31:0] seen_count,
	input logic [2:0]  distinct_shapes,
	input logic        table_full
);

	import sicp_pkg::*;

	`SICP_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result shown while busy")
	`SICP_ASSERT(a_take_busy, clk, arst_n, (start && !busy) |=> busy, "beat taken but not busy")
	`SICP_ASSERT(a_full_zero, clk, arst_n, (done && table_full) |-> (!newly_allocated && slot_number == 6'd0 && seen_count == 32'd0 && distinct_shapes == 3'd0), "full result not cleared")
	`SICP_ASSERT(a_new_mono, clk, arst_n, (done && newly_allocated) |-> (seen_count == 32'd1 && site_kind == KIND_MONO && distinct_shapes == 3'd1 && !table_full), "fresh slot result wrong")
	`SICP_ASSERT(a_hit_count, clk, arst_n, (done && !table_full) |-> (seen_count != 32'd0), "zero count on stored slot")

endmodule

bind shape_inline_cache_profiler_unit sicp_checker u_sicp_checker (.*);
